// ===== src/stepper_uart_datagram_encoder_top_defines.svh =====
// Assertion macros for the stepper UART datagram encoder.
// Included by the top level; depends on nothing else.
`ifndef STEPPER_UART_DATAGRAM_ENCODER_TOP_DEFINES_SVH
`define STEPPER_UART_DATAGRAM_ENCODER_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SUDE_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define SUDE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/sude_pkg.sv =====
// Shared types, constants and the CRC-8 byte update for the datagram encoder.
// No dependencies.
package sude_pkg;

   typedef logic [2:0] byte_idx_type;

   localparam logic       ACTION_WRITE = 1'b0;
   localparam logic       ACTION_READ  = 1'b1;

   localparam logic [7:0] SYNC_BYTE  = 8'h05;
   localparam logic [7:0] CRC_POLY   = 8'h07;
   localparam logic [7:0] WRITE_FLAG = 8'h80;

   localparam byte_idx_type IDX_SYNC   = 3'd0;
   localparam byte_idx_type IDX_NODE   = 3'd1;
   localparam byte_idx_type IDX_REG    = 3'd2;
   localparam byte_idx_type IDX_VAL3   = 3'd3;
   localparam byte_idx_type IDX_VAL2   = 3'd4;
   localparam byte_idx_type IDX_VAL1   = 3'd5;
   localparam byte_idx_type IDX_VAL0   = 3'd6;
   localparam byte_idx_type IDX_CRC_WR = 3'd7;
   localparam byte_idx_type IDX_CRC_RD = 3'd3;

   // Feed one byte, least significant bit first, into the running CRC.
   function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc;
      for (int i = 0; i < 8; i++) begin
         if (c[7] ^ data[i]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ===== src/sude_req_if.sv =====
// Request channel: one datagram request per word.
// No dependencies.
interface sude_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [6:0]  reg_address;
   logic [31:0] write_value;

   modport source (output valid, output action, output reg_address, output write_value,
                   input ready);
   modport sink   (input valid, input action, input reg_address, input write_value,
                   output ready);
endinterface

// ===== src/sude_rsp_if.sv =====
// Result channel: one datagram byte per word, flagged on the closing CRC byte.
// No dependencies.
interface sude_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_byte;

   modport source (output valid, output out_byte, output last_byte, input ready);
   modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

// ===== src/stepper_uart_datagram_encoder_top.sv =====
// A request is registered; its sync byte then enters the output register when free.
// Throughput: one byte per cycle when not stalled; writes 8 bytes, reads 4; the next
// request is taken in the cycle the closing CRC byte moves into the output register.
// The CRC is updated byte by byte as each byte is emitted.
// Reset (synchronous, active high): clears node address, busy flag and output valid.
// Depends on sude_pkg, sude_req_if, sude_rsp_if and the assertion macro header.
`include "stepper_uart_datagram_encoder_top_defines.svh"

module stepper_uart_datagram_encoder_top
   import sude_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_data,
   sude_req_if.sink   req_if,
   sude_rsp_if.source rsp_if
);

   logic [7:0]   node_ff;
   logic         busy_ff, busy_in;
   byte_idx_type idx_ff, idx_in;
   logic         act_ff;
   logic [6:0]   reg_ff;
   logic [31:0]  val_ff;
   logic [7:0]   crc_ff, crc_in;
   logic         out_valid_ff, out_valid_in;
   logic [7:0]   out_byte_ff, out_byte_in;
   logic         out_last_ff, out_last_in;

   logic         load_out;
   logic         is_last;
   logic         req_fire;
   logic [7:0]   cur_byte;

   assign csr_ready = 1'b1;

   assign is_last  = (idx_ff == ((act_ff == ACTION_READ) ? IDX_CRC_RD : IDX_CRC_WR));
   assign load_out = busy_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready = !busy_ff || (load_out && is_last);
   assign req_fire = req_if.valid && req_if.ready;

   // Pick the byte at the current position.
   always_comb begin
      case (idx_ff)
         IDX_SYNC: cur_byte = SYNC_BYTE;
         IDX_NODE: cur_byte = node_ff;
         IDX_REG:  cur_byte = (act_ff == ACTION_READ) ? {1'b0, reg_ff}
                                                      : ({1'b0, reg_ff} | WRITE_FLAG);
         IDX_VAL3: cur_byte = (act_ff == ACTION_READ) ? crc_ff : val_ff[31:24];
         IDX_VAL2: cur_byte = val_ff[23:16];
         IDX_VAL1: cur_byte = val_ff[15:8];
         IDX_VAL0: cur_byte = val_ff[7:0];
         default:  cur_byte = crc_ff;
      endcase
   end

   always_comb begin
      busy_in      = busy_ff;
      idx_in       = idx_ff;
      crc_in       = crc_ff;
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (load_out) begin
         out_valid_in = 1'b1;
         out_byte_in  = cur_byte;
         out_last_in  = is_last;
         crc_in       = crc8_feed(crc_ff, cur_byte);
         idx_in       = idx_ff + 3'd1;
         if (is_last) begin
            busy_in = 1'b0;
         end
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
      // Start a new datagram.
      if (req_fire) begin
         busy_in = 1'b1;
         idx_in  = IDX_SYNC;
         crc_in  = 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_ff      <= 8'h00;
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            node_ff <= csr_data;
         end
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      crc_ff      <= crc_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
      if (req_fire) begin
         act_ff <= req_if.action;
         reg_ff <= req_if.reg_address;
         val_ff <= req_if.write_value;
      end
   end

   assign rsp_if.valid     = out_valid_ff;
   assign rsp_if.out_byte  = out_byte_ff;
   assign rsp_if.last_byte = out_last_ff;

   `SUDE_ASSERT_NOW(a_take_only_at_end, clock, reset, req_fire && busy_ff, load_out && is_last,
      "request taken while a datagram is still mid-flight")
   `SUDE_ASSERT_NEXT(a_start_clean, clock, reset, req_fire,
      busy_ff && idx_ff == IDX_SYNC && crc_ff == 8'h00, "datagram did not start at sync byte")
   `SUDE_ASSERT_NEXT(a_last_flagged, clock, reset, load_out && is_last && !req_fire,
      rsp_if.valid && rsp_if.last_byte && !busy_ff, "closing byte not flagged")
   `SUDE_ASSERT_NOW(a_read_short, clock, reset, busy_ff && act_ff == ACTION_READ,
      idx_ff <= IDX_CRC_RD, "read datagram ran past its CRC byte")

endmodule
